/* hw/rtl/sme_pkg.sv */
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and constants of the stable matching engine.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int NumAgentsDef = 8;
  localparam int FieldW       = 3;

  typedef enum logic [1:0] {
    OpLoadDept = 2'd0,
    OpLoadProg = 2'd1,
    OpStart    = 2'd2
  } sme_op_e;

  typedef struct packed {
    logic store;
    logic clear_run;
    logic next_dept;
    logic rd_dept;
    logic latch_p;
    logic bump_d;
    logic bump_held;
    logic match_free;
    logic match_steal;
    logic clr_rank;
    logic rd_prog;
    logic next_rank;
    logic emit_res;
    logic emit_fail;
  } sme_cmd_t;

  typedef struct packed {
    logic run_done;
    logic cur_matched;
    logic choices_out;
    logic p_invalid;
    logic p_taken;
    logic hit_d;
    logic hit_h;
    logic rank_last;
    logic emit_last;
    logic out_free;
  } sme_sts_t;

endpackage

/* hw/rtl/sme_ctrl.sv */
// ----------------------------------------------------------------------------
// sme_ctrl
// Sequencer of the matching run: loads, proposals, rank scans and result
// emission.
// ----------------------------------------------------------------------------
module sme_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sme_pkg::sme_op_e  op_i,
  input  sme_pkg::sme_sts_t sts_i,
  output sme_pkg::sme_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDeptRead,
    StRankRead,
    StRankCmp,
    StBump,
    StEmit,
    StFail
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          case (op_i)
            sme_pkg::OpLoadDept, sme_pkg::OpLoadProg: cmd_o.store = 1'b1;
            sme_pkg::OpStart: begin
              cmd_o.clear_run = 1'b1;
              state_d         = StScan;
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        if (sts_i.run_done) begin
          state_d = StEmit;
        end else if (sts_i.cur_matched) begin
          cmd_o.next_dept = 1'b1;
        end else if (sts_i.choices_out) begin
          state_d = StFail;
        end else begin
          cmd_o.rd_dept = 1'b1;
          state_d       = StDeptRead;
        end
      end
      StDeptRead: begin
        if (sts_i.p_invalid) begin
          cmd_o.bump_d = 1'b1;
          state_d      = StScan;
        end else if (!sts_i.p_taken) begin
          cmd_o.match_free = 1'b1;
          state_d          = StScan;
        end else begin
          cmd_o.latch_p  = 1'b1;
          cmd_o.clr_rank = 1'b1;
          state_d        = StRankRead;
        end
      end
      StRankRead: begin
        cmd_o.rd_prog = 1'b1;
        state_d       = StRankCmp;
      end
      StRankCmp: begin
        if (sts_i.hit_d) begin
          cmd_o.match_steal = 1'b1;
          state_d           = StBump;
        end else if (sts_i.hit_h || sts_i.rank_last) begin
          cmd_o.bump_d = 1'b1;
          state_d      = StScan;
        end else begin
          cmd_o.next_rank = 1'b1;
          state_d         = StRankRead;
        end
      end
      StBump: begin
        cmd_o.bump_held = 1'b1;
        state_d         = StScan;
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit_res = 1'b1;
          if (sts_i.emit_last) state_d = StIdle;
        end
      end
      StFail: begin
        if (sts_i.out_free) begin
          cmd_o.emit_fail = 1'b1;
          state_d         = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/sme_datapath.sv */
// ----------------------------------------------------------------------------
// sme_datapath
// Preference memories, per-agent match state and the result register.
// ----------------------------------------------------------------------------
module sme_datapath #(
  parameter int NumAgents = sme_pkg::NumAgentsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sme_pkg::sme_cmd_t           cmd_i,
  output sme_pkg::sme_sts_t           sts_o,
  input  sme_pkg::sme_op_e            op_i,
  input  logic [sme_pkg::FieldW-1:0]  owner_i,
  input  logic [sme_pkg::FieldW-1:0]  rank_i,
  input  logic [sme_pkg::FieldW-1:0]  choice_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [sme_pkg::FieldW-1:0]  department_o,
  output logic [sme_pkg::FieldW-1:0]  programmer_o,
  output logic                        status_o,
  output logic                        last_o
);

  localparam int FieldW = sme_pkg::FieldW;
  localparam int IdxW   = $clog2(NumAgents);
  localparam int CntW   = $clog2(NumAgents + 1);
  localparam int Depth  = NumAgents * NumAgents;
  localparam int AddrW  = $clog2(Depth);

  logic [FieldW-1:0] dept_mem [Depth];
  logic [FieldW-1:0] prog_mem [Depth];
  logic [FieldW-1:0] dept_rd_q;
  logic [FieldW-1:0] prog_rd_q;

  logic [CntW-1:0]   nc_q [NumAgents];
  logic [IdxW-1:0]   dept_partner_q [NumAgents];
  logic [IdxW-1:0]   prog_partner_q [NumAgents];
  logic [NumAgents-1:0] dept_free_q;
  logic [NumAgents-1:0] prog_taken_q;

  logic [IdxW-1:0]   d_q, p_q, held_q, r_q, e_q;
  logic [CntW-1:0]   cnt_q;

  logic              out_valid_q, status_q, last_q;
  logic [FieldW-1:0] department_q, programmer_q;

  logic              load_ok;
  logic [AddrW-1:0]  waddr, dept_raddr, prog_raddr;
  logic [IdxW-1:0]   nc_idx, p_idx;
  logic [CntW-1:0]   nc_sel;
  logic              out_free;

  assign load_ok = (int'(owner_i) < NumAgents) && (int'(rank_i) < NumAgents) &&
                   (int'(choice_i) < NumAgents);
  assign waddr      = AddrW'(int'(owner_i) * NumAgents + int'(rank_i));
  assign nc_idx     = cmd_i.bump_held ? held_q : d_q;
  assign nc_sel     = nc_q[nc_idx];
  assign dept_raddr = AddrW'(int'(d_q) * NumAgents + int'(nc_sel));
  assign prog_raddr = AddrW'(int'(p_q) * NumAgents + int'(r_q));
  assign p_idx      = IdxW'(dept_rd_q);
  assign out_free   = !out_valid_q || out_ready_i;

  // preference memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && load_ok && (op_i == sme_pkg::OpLoadDept)) begin
      dept_mem[waddr] <= choice_i;
    end
    if (cmd_i.rd_dept) begin
      dept_rd_q <= dept_mem[dept_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && load_ok && (op_i == sme_pkg::OpLoadProg)) begin
      prog_mem[waddr] <= choice_i;
    end
    if (cmd_i.rd_prog) begin
      prog_rd_q <= prog_mem[prog_raddr];
    end
  end

  // partner values
  always_ff @(posedge clk_i) begin
    if (cmd_i.match_free) begin
      dept_partner_q[d_q]   <= p_idx;
      prog_partner_q[p_idx] <= d_q;
    end
    if (cmd_i.match_steal) begin
      dept_partner_q[d_q] <= p_q;
      prog_partner_q[p_q] <= d_q;
    end
    if (cmd_i.latch_p) begin
      p_q    <= p_idx;
      held_q <= prog_partner_q[p_idx];
    end
  end

  // run control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumAgents; i++) nc_q[i] <= '0;
      dept_free_q  <= '1;
      prog_taken_q <= '0;
      d_q          <= '0;
      r_q          <= '0;
      e_q          <= '0;
      cnt_q        <= '0;
    end else begin
      if (cmd_i.clear_run) begin
        for (int i = 0; i < NumAgents; i++) nc_q[i] <= '0;
        dept_free_q  <= '1;
        prog_taken_q <= '0;
        d_q          <= '0;
        e_q          <= '0;
        cnt_q        <= '0;
      end
      if (cmd_i.next_dept) begin
        d_q <= (int'(d_q) == NumAgents - 1) ? '0 : d_q + 1'b1;
      end
      if (cmd_i.bump_d || cmd_i.bump_held) begin
        nc_q[nc_idx] <= nc_sel + 1'b1;
      end
      if (cmd_i.match_free) begin
        dept_free_q[d_q]    <= 1'b0;
        prog_taken_q[p_idx] <= 1'b1;
        cnt_q               <= cnt_q + 1'b1;
      end
      if (cmd_i.match_steal) begin
        dept_free_q <= (dept_free_q & ~(NumAgents'(1) << d_q)) |
                       (NumAgents'(1) << held_q);
      end
      if (cmd_i.clr_rank) begin
        r_q <= '0;
      end
      if (cmd_i.next_rank) begin
        r_q <= r_q + 1'b1;
      end
      if (cmd_i.emit_res) begin
        e_q <= e_q + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_res || cmd_i.emit_fail) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_res) begin
      department_q <= FieldW'(e_q);
      programmer_q <= FieldW'(dept_partner_q[e_q]);
      status_q     <= 1'b0;
      last_q       <= (int'(e_q) == NumAgents - 1);
    end else if (cmd_i.emit_fail) begin
      department_q <= FieldW'(d_q);
      programmer_q <= '0;
      status_q     <= 1'b1;
      last_q       <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign department_o = department_q;
  assign programmer_o = programmer_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

  always_comb begin
    sts_o             = '0;
    sts_o.run_done    = (int'(cnt_q) == NumAgents);
    sts_o.cur_matched = !dept_free_q[d_q];
    sts_o.choices_out = (int'(nc_sel) >= NumAgents);
    sts_o.p_invalid   = (int'(dept_rd_q) >= NumAgents);
    sts_o.p_taken     = prog_taken_q[p_idx];
    sts_o.hit_d       = (int'(prog_rd_q) == int'(d_q));
    sts_o.hit_h       = (int'(prog_rd_q) == int'(held_q));
    sts_o.rank_last   = (int'(r_q) == NumAgents - 1);
    sts_o.emit_last   = (int'(e_q) == NumAgents - 1);
    sts_o.out_free    = out_free;
  end

endmodule

/* hw/rtl/stable_matching_engine_top.sv */
// ----------------------------------------------------------------------------
// stable_matching_engine_top
// Department-proposing stable matching of NumAgents departments to as many
// programmers.
// ----------------------------------------------------------------------------
// usage
//   input channel: operation 0 or 1 writes one preference entry (owner, rank,
//   choice); one transfer per cycle is taken while idle.
//   entries out of range are dropped. operation 2 starts a run; code 3 is
//   ignored. in_ready_o is low while a run is in progress.
//   output channel: one transfer per department in department order, last_o
//   on the final one, or a single transfer with status_o set when a
//   department exhausts its list.
//   run steps: each proposal reads the department's next choice (scan, then
//   dept read); when the programmer is already held, its list is scanned
//   entry by entry, each read of the preference memory followed by a
//   compare, and a bump step follows when the programmer changes hands;
//   a matched department is skipped in the scan, and results emit in turn.
//   a stalled receiver holds the result register; emission pauses until it
//   frees up, and loads are taken again once the last result is registered.
//   reset clears the run state; preference memories hold no reset value.
// ----------------------------------------------------------------------------
module stable_matching_engine_top #(
  parameter int NumAgents = sme_pkg::NumAgentsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 operation_i,
  input  logic [sme_pkg::FieldW-1:0] owner_index_i,
  input  logic [sme_pkg::FieldW-1:0] rank_index_i,
  input  logic [sme_pkg::FieldW-1:0] choice_id_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [sme_pkg::FieldW-1:0] department_o,
  output logic [sme_pkg::FieldW-1:0] programmer_o,
  output logic                       status_o,
  output logic                       last_o
);

  sme_pkg::sme_cmd_t cmd;
  sme_pkg::sme_sts_t sts;
  sme_pkg::sme_op_e  op;

  assign op = sme_pkg::sme_op_e'(operation_i);

  sme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sme_datapath #(
    .NumAgents (NumAgents)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (op),
    .owner_i      (owner_index_i),
    .rank_i       (rank_index_i),
    .choice_i     (choice_id_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .department_o (department_o),
    .programmer_o (programmer_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_res || cmd.emit_fail) |-> (!out_valid_o || out_ready_i))
    else $error("result loaded over an untaken transfer");

  a_fail_result_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (last_o && (programmer_o == '0)))
    else $error("failure result not marked last");

  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.match_free, cmd.match_steal, cmd.bump_d, cmd.next_dept,
              cmd.store, cmd.clear_run}))
    else $error("conflicting match state updates");

  a_idle_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(cmd.rd_dept || cmd.rd_prog || cmd.emit_res))
    else $error("run activity while accepting input");

endmodule
